// ----- hw/rtl/mfek_pkg.sv -----
`timescale 1ns / 1ps

package mfek_pkg;

  localparam int NV = 64;
  localparam int V_BITS = 6;
  localparam int CAP_BITS = 16;
  localparam int TOTAL_BITS = 22;
  localparam int ADDR_BITS = 2 * V_BITS;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD = 2'd1;
  localparam logic [1:0] KIND_RUN = 2'd2;
  localparam logic [1:0] KIND_NOP = 2'd3;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_SAME = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [V_BITS-1:0]   from_vertex;
    logic [V_BITS-1:0]   to_vertex;
    logic [CAP_BITS-1:0] capacity;
    logic [V_BITS-1:0]   source_vertex;
    logic [V_BITS-1:0]   sink_vertex;
  } in_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] total_flow;
    logic [1:0]            status;
  } out_t;

  typedef struct packed {
    logic                present;
    logic [CAP_BITS-1:0] cap;
    logic [CAP_BITS-1:0] flow;
  } edge_t;

endpackage

// ----- hw/rtl/max_flow_edmonds_karp_top.sv -----
`timescale 1ns / 1ps

// Edmonds-Karp maximum flow over a 64-vertex adjacency matrix held in one
// 4096-entry memory with two read ports. After reset, and after every clear
// beat, the block sweeps the whole edge memory and accepts no beat meanwhile.
// An add-edge beat does two read-modify-writes. A run beat, for each augmenting
// path, runs a breadth-first search in which the scan of every vertex taken
// off the search queue reads one matrix entry pair per cycle, and then walks
// the path edges twice, for the bottleneck and for the augment.
// A result is held in an output register until taken.
module max_flow_edmonds_karp_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mfek_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output mfek_pkg::out_t   out_data,
  input  logic             cfg_we,
  input  logic [6:0]       cfg_data
);

  typedef enum logic [3:0] {
    IDLE, SWEEP, ADD_RD, ADD_WR, S_INIT, S_DEQ, S_DEQW, S_SCAN, S_NEXT,
    W_PAR, W_EDGE, W_CALC, RESULT
  } state_t;

  state_t state;
  logic [6:0] vcount;
  logic [6:0] act_n;
  mfek_pkg::in_t item;
  logic [mfek_pkg::ADDR_BITS-1:0] sweep_addr;
  logic add_second;
  logic [5:0] now, scan_nx, p1_nx, walk_v, walk_p;
  logic p1_valid, scan_issue, walk_rev, walk_aug;
  logic [6:0] head, tail;
  logic [mfek_pkg::NV-1:0] visited;
  logic [15:0] bneck;
  logic [21:0] total;
  logic [1:0] status;

  mfek_pkg::edge_t edge_mem [4096];
  logic [6:0] par_mem [mfek_pkg::NV];
  logic [5:0] q_mem [mfek_pkg::NV];

  logic [11:0] addr_a, addr_b, edge_wa;
  logic edge_we;
  mfek_pkg::edge_t edge_wd, rd_a, rd_b;
  logic [5:0] par_ra, q_ra, par_wa, q_wa, q_wd;
  logic [6:0] par_rd, par_wd;
  logic [5:0] q_rd;
  logic par_we, q_we;

  logic take, fwd_ok;
  logic [15:0] resid, bneck_new;
  logic [16:0] cap_sum;
  logic [22:0] tot_sum;

  assign act_n = (vcount > 7'(mfek_pkg::NV)) ? 7'(mfek_pkg::NV) : vcount;
  assign in_ready = (state == IDLE);

  assign fwd_ok = rd_a.cap > rd_a.flow;
  assign take = p1_valid && rd_a.present && !visited[p1_nx] &&
                (fwd_ok || (rd_b.flow != '0));
  assign resid = walk_rev ? rd_b.flow : 16'(rd_a.cap - rd_a.flow);
  assign bneck_new = (resid < bneck) ? resid : bneck;
  assign cap_sum = {1'b0, rd_a.cap} + {1'b0, item.capacity};
  assign tot_sum = {1'b0, total} + {7'b0, bneck};

  always_comb begin
    addr_a = '0;
    addr_b = '0;
    edge_we = 1'b0;
    edge_wa = '0;
    edge_wd = rd_a;
    par_ra = walk_v;
    q_ra = head[5:0];
    par_we = 1'b0;
    par_wa = p1_nx;
    par_wd = {!fwd_ok, now};
    q_we = 1'b0;
    q_wa = tail[5:0];
    q_wd = p1_nx;
    unique case (state)
      SWEEP: begin
        edge_we = 1'b1;
        edge_wa = sweep_addr;
        edge_wd = '0;
      end
      ADD_RD: begin
        addr_a = add_second ? {item.to_vertex, item.from_vertex}
                            : {item.from_vertex, item.to_vertex};
      end
      ADD_WR: begin
        edge_we = 1'b1;
        edge_wa = add_second ? {item.to_vertex, item.from_vertex}
                             : {item.from_vertex, item.to_vertex};
        edge_wd.present = 1'b1;
        if (!add_second) begin
          edge_wd.cap = cap_sum[16] ? '1 : cap_sum[15:0];
        end
      end
      S_INIT: begin
        q_we = 1'b1;
        q_wa = '0;
        q_wd = item.source_vertex;
      end
      S_SCAN: begin
        addr_a = {now, scan_nx};
        addr_b = {scan_nx, now};
        par_we = take;
        q_we = take;
      end
      W_EDGE: begin
        addr_a = {par_rd[5:0], walk_v};
        addr_b = {walk_v, par_rd[5:0]};
      end
      W_CALC: begin
        if (walk_aug) begin
          edge_we = 1'b1;
          if (walk_rev) begin
            edge_wa = {walk_v, walk_p};
            edge_wd = rd_b;
            edge_wd.flow = 16'(rd_b.flow - bneck);
          end else begin
            edge_wa = {walk_p, walk_v};
            edge_wd = rd_a;
            edge_wd.flow = 16'(rd_a.flow + bneck);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_a <= edge_mem[addr_a];
    rd_b <= edge_mem[addr_b];
    if (edge_we) begin
      edge_mem[edge_wa] <= edge_wd;
    end
  end

  always_ff @(posedge clk) begin
    par_rd <= par_mem[par_ra];
    if (par_we) begin
      par_mem[par_wa] <= par_wd;
    end
  end

  always_ff @(posedge clk) begin
    q_rd <= q_mem[q_ra];
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SWEEP;
      sweep_addr <= '0;
      vcount <= 7'd64;
      total <= '0;
      out_valid <= 1'b0;
      p1_valid <= 1'b0;
      scan_issue <= 1'b0;
      visited <= '0;
      head <= '0;
      tail <= '0;
      bneck <= '1;
    end else begin
      if (cfg_we) begin
        vcount <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            item <= in_data;
            case (in_data.kind)
              mfek_pkg::KIND_CLEAR: begin
                sweep_addr <= '0;
                total <= '0;
                state <= SWEEP;
              end
              mfek_pkg::KIND_ADD: begin
                if ({1'b0, in_data.from_vertex} >= act_n ||
                    {1'b0, in_data.to_vertex} >= act_n) begin
                  status <= mfek_pkg::STATUS_RANGE;
                  state <= RESULT;
                end else begin
                  add_second <= 1'b0;
                  state <= ADD_RD;
                end
              end
              mfek_pkg::KIND_RUN: begin
                if ({1'b0, in_data.source_vertex} >= act_n ||
                    {1'b0, in_data.sink_vertex} >= act_n) begin
                  status <= mfek_pkg::STATUS_RANGE;
                  state <= RESULT;
                end else if (in_data.source_vertex == in_data.sink_vertex) begin
                  status <= mfek_pkg::STATUS_SAME;
                  state <= RESULT;
                end else begin
                  status <= mfek_pkg::STATUS_OK;
                  state <= S_INIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == '1) begin
            state <= IDLE;
          end
        end
        ADD_RD: state <= ADD_WR;
        ADD_WR: begin
          add_second <= 1'b1;
          state <= add_second ? IDLE : ADD_RD;
        end
        S_INIT: begin
          visited <= {{(mfek_pkg::NV-1){1'b0}}, 1'b1} << item.source_vertex;
          head <= '0;
          tail <= 7'd1;
          state <= S_DEQ;
        end
        S_DEQ: begin
          head <= head + 1'b1;
          state <= S_DEQW;
        end
        S_DEQW: begin
          now <= q_rd;
          scan_nx <= '0;
          scan_issue <= 1'b1;
          p1_valid <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          p1_valid <= scan_issue;
          p1_nx <= scan_nx;
          if (scan_issue) begin
            scan_nx <= scan_nx + 1'b1;
            if (scan_nx == 6'(act_n - 1'b1)) begin
              scan_issue <= 1'b0;
            end
          end
          if (take) begin
            visited[p1_nx] <= 1'b1;
            tail <= tail + 1'b1;
          end
          if (p1_valid && p1_nx == 6'(act_n - 1'b1)) begin
            p1_valid <= 1'b0;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (visited[item.sink_vertex]) begin
            walk_v <= item.sink_vertex;
            walk_aug <= 1'b0;
            bneck <= '1;
            state <= W_PAR;
          end else if (head < tail) begin
            state <= S_DEQ;
          end else begin
            state <= RESULT;
          end
        end
        W_PAR: state <= W_EDGE;
        W_EDGE: begin
          walk_rev <= par_rd[6];
          walk_p <= par_rd[5:0];
          state <= W_CALC;
        end
        W_CALC: begin
          walk_v <= walk_p;
          state <= W_PAR;
          if (!walk_aug) begin
            bneck <= bneck_new;
          end
          if (walk_p == item.source_vertex) begin
            if (!walk_aug) begin
              if (bneck_new == '0) begin
                state <= RESULT;
              end else begin
                walk_v <= item.sink_vertex;
                walk_aug <= 1'b1;
              end
            end else begin
              total <= tot_sum[22] ? '1 : tot_sum[21:0];
              state <= S_INIT;
            end
          end
        end
        RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.total_flow <= total;
            out_data.status <= status;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_src_visited: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> visited[item.source_vertex])
    else $error("source not marked visited during scan");

  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && take) |-> (tail < 7'(mfek_pkg::NV)))
    else $error("search queue overflow");

  a_aug_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == W_CALC && walk_aug) |-> (bneck != '0))
    else $error("augment with zero bottleneck");
`endif

endmodule
